/* src/nand_block_chunk_manager_macros.svh */
// Assertion macros shared by the chunk manager RTL.
// Depends on a clock named clock and a synchronous active-high reset named reset.
`ifndef NAND_BLOCK_CHUNK_MANAGER_MACROS_SVH
`define NAND_BLOCK_CHUNK_MANAGER_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define NBCM_ASSERT_SAME(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define NBCM_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

/* src/nbcm_pkg.sv */
// Shared types and constants of the NAND block chunk manager.
// No dependencies; used by nbcm_div and nand_block_chunk_manager.
package nbcm_pkg;

   localparam int BLOCK_COUNT_DEF = 1024;
   localparam int MAX_PAGES_DEF   = 64;

   localparam int CHUNK_W = 16;
   localparam int BLKIN_W = 10;
   localparam int CNT_W   = 7;
   localparam int SEQ_W   = 32;
   localparam int ERA_W   = 11;
   localparam int ST_W    = 4;

   localparam logic [ERA_W-1:0] CNT_MAX = 11'd2047;

   // Block state codes.
   localparam logic [ST_W-1:0] BS_EMPTY = 4'd1;
   localparam logic [ST_W-1:0] BS_ALLOC = 4'd2;
   localparam logic [ST_W-1:0] BS_DEAD  = 4'd3;

   typedef enum logic [2:0] {
      OP_ALLOC, OP_WRITE, OP_DELETE, OP_ERASE,
      OP_MARK_BAD, OP_RETIRE, OP_SET_STATE, OP_QUERY
   } op_type;

   typedef enum logic [1:0] {
      STS_OK, STS_NO_BLOCK, STS_FLASH_FAIL
   } status_type;

   typedef enum logic [2:0] {
      CSR_CPB, CSR_FIRST, CSR_LAST, CSR_RESERVE, CSR_NO_BAD
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DIV, S_READ, S_EXEC, S_SETUP, S_SCAN, S_STAMP
   } fsm_type;

   // One block record as held in the record memory.
   typedef struct packed {
      logic [ST_W-1:0]  state;
      logic [SEQ_W-1:0] seq;
      logic [CNT_W-1:0] used;
      logic [CNT_W-1:0] deleted;
      logic             retire;
   } blk_rec_type;

   typedef struct packed {
      logic               start;
      logic [CHUNK_W-1:0] dividend;
      logic [CNT_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [CHUNK_W-1:0] quotient;
      logic [CNT_W-1:0]   remainder;
   } div_rsp_type;

endpackage

/* src/nand_block_chunk_manager.sv */
// NAND block table and chunk allocator, top level with record and bitmap memories.
// Depends on nbcm_pkg, nbcm_div and nand_block_chunk_manager_macros.svh.
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+------------------------------
//  request   | start, busy, req_*            | beat taken when start & !busy
//  response  | rsp_valid, rsp_*              | one-cycle strobe, no stall
//  registers | csr_valid, csr_ready, csr_*   | write when valid & ready
//
// After reset a clearing pass writes every block entry with busy high;
// register writes are taken during it.
// Block operations read, modify and write back one record (a continued allocation only
// reads); chunk operations first use the divider that splits the chunk number.
// A fresh allocation scans block states through the record memory read port,
// one block per cycle; its worst case is two passes of the window.
// The response strobe lasts one cycle; the receiver cannot hold it off.
`include "nand_block_chunk_manager_macros.svh"
module nand_block_chunk_manager
   import nbcm_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
   parameter int MAX_PAGES   = MAX_PAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [CHUNK_W-1:0] req_chunk,
   input  logic [BLKIN_W-1:0] req_block,
   input  logic               req_use_reserve,
   input  logic               req_flash_ok,
   input  logic [ST_W-1:0]    req_new_state,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [CHUNK_W-1:0] rsp_chunk_out,
   output logic               rsp_chunk_used,
   output logic [ST_W-1:0]    rsp_block_status,
   output logic [SEQ_W-1:0]   rsp_block_sequence,
   output logic [CNT_W-1:0]   rsp_pages_used,
   output logic [CNT_W-1:0]   rsp_pages_deleted,
   output logic               rsp_retire_pending,
   output logic [ERA_W-1:0]   rsp_erased_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [BLKIN_W-1:0] csr_data
);

   localparam int BW  = $clog2(BLOCK_COUNT);
   localparam int PGW = $clog2(MAX_PAGES);
   localparam int PW  = ((BW > BLKIN_W) ? BW : BLKIN_W) + 1;

   // Configuration registers.
   logic [CNT_W-1:0]   cpb_ff;
   logic [BLKIN_W-1:0] first_ff, last_ff, rsv_ff;
   logic               nobad_ff;

   // Allocator state.
   fsm_type            state_ff, state_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [BW-1:0]      cur_blk_ff, cur_blk_in;
   logic [CNT_W-1:0]   cur_page_ff, cur_page_in;
   logic [BLKIN_W-1:0] search_ff, search_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [ERA_W-1:0]   erased_ff, erased_in;
   logic [ERA_W-1:0]   retired_ff, retired_in;
   logic [BW-1:0]      clr_ff, clr_in;

   // Latched request beat.
   op_type             op_ff, op_in;
   logic               use_res_ff, use_res_in;
   logic               ok_ff, ok_in;
   logic [ST_W-1:0]    nst_ff, nst_in;

   // Work registers of the current operation.
   logic [BW-1:0]      tgt_ff, tgt_in;
   logic [PGW-1:0]     cp_ff, cp_in;
   logic [PW-1:0]      ptr_ff, ptr_in;
   logic               pass_ff, pass_in;
   logic               infl_ff, infl_in;
   logic [BW-1:0]      infl_addr_ff, infl_addr_in;

   // Response registers.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         sts_ff, sts_in;
   logic [CHUNK_W-1:0] cout_ff, cout_in;
   logic               cused_ff, cused_in;
   blk_rec_type        orec_ff, orec_in;
   logic [ERA_W-1:0]   oera_ff;

   // Memories and their ports.
   blk_rec_type        rec_mem [BLOCK_COUNT];
   logic [MAX_PAGES-1:0] map_mem [BLOCK_COUNT];
   blk_rec_type        rd_rec_ff, wr_rec;
   logic [MAX_PAGES-1:0] rd_map_ff, wr_map;
   logic               rd_en, we;
   logic [BW-1:0]      rd_addr, wr_addr;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // Decisions shared by the next-state and datapath logic.
   logic [CNT_W-1:0]   eff_cpb;
   logic [PW-1:0]      lim_w, from_w;
   logic [BLKIN_W-1:0] reserve;
   logic               room, hit, more, cur_ok, q_ok, blk_ok, is_chunk_op;
   logic [BW+CNT_W-1:0] cur_prod, tgt_prod;

   always_comb begin
      if (cpb_ff == '0) begin
         eff_cpb = CNT_W'(1);
      end else if (cpb_ff > CNT_W'(MAX_PAGES)) begin
         eff_cpb = CNT_W'(MAX_PAGES);
      end else begin
         eff_cpb = cpb_ff;
      end
      lim_w = (PW'(last_ff) > PW'(BLOCK_COUNT - 1)) ? PW'(BLOCK_COUNT - 1) : PW'(last_ff);
      from_w = (search_ff < first_ff) ? PW'(first_ff) : PW'(search_ff);
      reserve = use_res_ff ? '0 : rsv_ff;
      room = erased_ff > ERA_W'(reserve);
      hit = infl_ff && (rd_rec_ff.state == BS_EMPTY);
      more = ptr_ff <= lim_w;
      cur_ok = (rd_rec_ff.state == BS_ALLOC) && (cur_page_ff < eff_cpb);
      q_ok = 32'(div_rsp.quotient) < 32'(BLOCK_COUNT);
      blk_ok = 32'(req_block) < 32'(BLOCK_COUNT);
      is_chunk_op = req_operation inside {OP_WRITE, OP_DELETE, OP_QUERY};
      cur_prod = (BW+CNT_W)'(cur_blk_ff) * (BW+CNT_W)'(eff_cpb);
      tgt_prod = (BW+CNT_W)'(tgt_ff) * (BW+CNT_W)'(eff_cpb);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == BW'(BLOCK_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (op_type'(req_operation) == OP_ALLOC) begin
                  state_in = cur_valid_ff ? S_READ : S_SETUP;
               end else if (is_chunk_op) begin
                  if (!(op_type'(req_operation) == OP_WRITE && !req_flash_ok)) state_in = S_DIV;
               end else if (blk_ok) begin
                  state_in = S_READ;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) state_in = q_ok ? S_READ : S_IDLE;
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            state_in = (op_ff == OP_ALLOC && !cur_ok) ? S_SETUP : S_IDLE;
         end
         S_SETUP: state_in = room ? S_SCAN : S_IDLE;
         S_SCAN: begin
            if (hit) begin
               state_in = S_STAMP;
            end else if (!more && pass_ff) begin
               state_in = S_IDLE;
            end
         end
         S_STAMP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory port control.
   always_comb begin
      blk_rec_type        rec;
      logic [MAX_PAGES-1:0] map;
      rec          = rd_rec_ff;
      map          = rd_map_ff;
      cur_valid_in = cur_valid_ff;
      cur_blk_in   = cur_blk_ff;
      cur_page_in  = cur_page_ff;
      search_in    = search_ff;
      seq_in       = seq_ff;
      erased_in    = erased_ff;
      retired_in   = retired_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      use_res_in   = use_res_ff;
      ok_in        = ok_ff;
      nst_in       = nst_ff;
      tgt_in       = tgt_ff;
      cp_in        = cp_ff;
      ptr_in       = ptr_ff;
      pass_in      = pass_ff;
      infl_in      = infl_ff;
      infl_addr_in = infl_addr_ff;
      rsp_valid_in = 1'b0;
      sts_in       = STS_OK;
      cout_in      = '0;
      cused_in     = 1'b0;
      orec_in      = '0;
      rd_en        = 1'b0;
      rd_addr      = tgt_ff;
      we           = 1'b0;
      wr_addr      = tgt_ff;
      wr_rec       = rec;
      wr_map       = map;
      div_req.start    = 1'b0;
      div_req.dividend = req_chunk;
      div_req.divisor  = eff_cpb;

      case (state_ff)
         // Zero one entry per cycle after reset.
         S_CLEAR: begin
            we      = 1'b1;
            wr_addr = clr_ff;
            wr_rec  = '0;
            wr_map  = '0;
            clr_in  = clr_ff + 1'b1;
         end
         // Take a request beat; answer at once for a failed write or an out-of-range block.
         S_IDLE: begin
            if (start) begin
               op_in      = op_type'(req_operation);
               use_res_in = req_use_reserve;
               ok_in      = req_flash_ok;
               nst_in     = req_new_state;
               if (op_type'(req_operation) == OP_ALLOC) begin
                  tgt_in = cur_blk_ff;
               end else if (is_chunk_op) begin
                  if (op_type'(req_operation) == OP_WRITE && !req_flash_ok) begin
                     rsp_valid_in = 1'b1;
                     sts_in       = STS_FLASH_FAIL;
                  end else begin
                     div_req.start = 1'b1;
                  end
               end else begin
                  tgt_in = BW'(req_block);
                  if (!blk_ok) begin
                     rsp_valid_in = 1'b1;
                     if (op_type'(req_operation) == OP_ERASE && !req_flash_ok) begin
                        sts_in = STS_FLASH_FAIL;
                     end
                  end
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               tgt_in = BW'(div_rsp.quotient);
               cp_in  = div_rsp.remainder[PGW-1:0];
               if (!q_ok) rsp_valid_in = 1'b1;
            end
         end
         S_READ: rd_en = 1'b1;
         // Modify the record read last cycle and write it back; a query or a continued allocation writes nothing.
         S_EXEC: begin
            case (op_ff)
               OP_ALLOC: begin
                  if (cur_ok) begin
                     rsp_valid_in = 1'b1;
                     cout_in      = CHUNK_W'(cur_prod + (BW+CNT_W)'(cur_page_ff));
                     cused_in     = map[cur_page_ff[PGW-1:0]];
                     orec_in      = rec;
                     cur_page_in  = cur_page_ff + 1'b1;
                  end else begin
                     cur_valid_in = 1'b0;
                  end
               end
               OP_WRITE, OP_DELETE, OP_QUERY: begin
                  if (op_ff == OP_WRITE) begin
                     map[cp_ff] = 1'b1;
                     if (rec.used < CNT_W'(MAX_PAGES)) rec.used = rec.used + 1'b1;
                     we = 1'b1;
                  end else if (op_ff == OP_DELETE) begin
                     map[cp_ff] = 1'b0;
                     if (rec.deleted < CNT_W'(MAX_PAGES)) rec.deleted = rec.deleted + 1'b1;
                     we = 1'b1;
                  end
                  rsp_valid_in = 1'b1;
                  cused_in     = map[cp_ff];
                  orec_in      = rec;
               end
               default: begin
                  if ((op_ff == OP_ERASE && !ok_ff) || op_ff == OP_MARK_BAD) begin
                     rec.state = BS_DEAD;
                     if (!nobad_ff && retired_ff < CNT_MAX) retired_in = retired_ff + 1'b1;
                  end else if (op_ff == OP_ERASE) begin
                     rec       = '0;
                     rec.state = BS_EMPTY;
                     map       = '0;
                     if (erased_ff < CNT_MAX) erased_in = erased_ff + 1'b1;
                  end else if (op_ff == OP_RETIRE) begin
                     rec.retire = 1'b1;
                  end else begin
                     rec.state = nst_ff;
                  end
                  we           = 1'b1;
                  rsp_valid_in = 1'b1;
                  if (op_ff == OP_ERASE && !ok_ff) sts_in = STS_FLASH_FAIL;
                  orec_in      = rec;
               end
            endcase
            wr_rec = rec;
            wr_map = map;
         end
         // Check the reserve and aim the finder.
         S_SETUP: begin
            if (room) begin
               ptr_in  = from_w;
               pass_in = 1'b0;
               infl_in = 1'b0;
            end else begin
               rsp_valid_in = 1'b1;
               sts_in       = STS_NO_BLOCK;
            end
         end
         // One block state read per cycle, checked the cycle after.
         S_SCAN: begin
            if (hit) begin
               tgt_in  = infl_addr_ff;
               infl_in = 1'b0;
            end else if (more) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_ff[BW-1:0];
               infl_in      = 1'b1;
               infl_addr_in = ptr_ff[BW-1:0];
               ptr_in       = ptr_ff + 1'b1;
            end else begin
               infl_in = 1'b0;
               if (!pass_ff) begin
                  search_in = first_ff;
                  pass_in   = 1'b1;
                  ptr_in    = PW'(first_ff);
               end else begin
                  rsp_valid_in = 1'b1;
                  sts_in       = STS_NO_BLOCK;
               end
            end
         end
         // Take the empty block found by the scan.
         S_STAMP: begin
            rec.state    = BS_ALLOC;
            rec.seq      = seq_ff;
            we           = 1'b1;
            wr_rec       = rec;
            seq_in       = seq_ff + 1'b1;
            cur_valid_in = 1'b1;
            cur_blk_in   = tgt_ff;
            cur_page_in  = CNT_W'(1);
            search_in    = BLKIN_W'(PW'(tgt_ff) + 1'b1);
            erased_in    = erased_ff - 1'b1;
            rsp_valid_in = 1'b1;
            cout_in      = CHUNK_W'(tgt_prod);
            cused_in     = map[0];
            orec_in      = rec;
         end
         default: ;
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cur_valid_ff <= 1'b0;
         cur_page_ff  <= '0;
         search_ff    <= '0;
         seq_ff       <= '0;
         erased_ff    <= '0;
         retired_ff   <= '0;
         infl_ff      <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_valid_ff <= cur_valid_in;
         cur_page_ff  <= cur_page_in;
         search_ff    <= search_in;
         seq_ff       <= seq_in;
         erased_ff    <= erased_in;
         retired_ff   <= retired_in;
         infl_ff      <= infl_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_blk_ff   <= cur_blk_in;
      op_ff        <= op_in;
      use_res_ff   <= use_res_in;
      ok_ff        <= ok_in;
      nst_ff       <= nst_in;
      tgt_ff       <= tgt_in;
      cp_ff        <= cp_in;
      ptr_ff       <= ptr_in;
      infl_addr_ff <= infl_addr_in;
      sts_ff       <= sts_in;
      cout_ff      <= cout_in;
      cused_ff     <= cused_in;
      orec_ff      <= orec_in;
      oera_ff      <= erased_in;
   end

   // Register file writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cpb_ff   <= CNT_W'(64);
         first_ff <= '0;
         last_ff  <= BLKIN_W'(1023);
         rsv_ff   <= BLKIN_W'(2);
         nobad_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_CPB:     cpb_ff   <= csr_data[CNT_W-1:0];
            CSR_FIRST:   first_ff <= csr_data;
            CSR_LAST:    last_ff  <= csr_data;
            CSR_RESERVE: rsv_ff   <= csr_data;
            CSR_NO_BAD:  nobad_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Record and bitmap memories; reads and writes never hit the same entry
   // in one cycle because each operation reads before it writes.
   always_ff @(posedge clock) begin
      if (we) begin
         rec_mem[wr_addr] <= wr_rec;
         map_mem[wr_addr] <= wr_map;
      end
      if (rd_en) begin
         rd_rec_ff <= rec_mem[rd_addr];
         rd_map_ff <= map_mem[rd_addr];
      end
   end

   nbcm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign busy               = state_ff != S_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = sts_ff;
   assign rsp_chunk_out      = cout_ff;
   assign rsp_chunk_used     = cused_ff;
   assign rsp_block_status   = orec_ff.state;
   assign rsp_block_sequence = orec_ff.seq;
   assign rsp_pages_used     = orec_ff.used;
   assign rsp_pages_deleted  = orec_ff.deleted;
   assign rsp_retire_pending = orec_ff.retire;
   assign rsp_erased_count   = oera_ff;

   `NBCM_ASSERT_SAME(a_no_rsp_in_clear, state_ff == S_CLEAR, !rsp_valid_ff, "response during clear")
   `NBCM_ASSERT_NEXT(a_beat_tracked, start && !busy, rsp_valid || busy, "request beat dropped")
   `NBCM_ASSERT_SAME(a_write_states, we, state_ff == S_CLEAR || state_ff == S_EXEC || state_ff == S_STAMP, "stray memory write")
   `NBCM_ASSERT_SAME(a_div_done_state, div_rsp.done, state_ff == S_DIV, "divider result unexpected")

endmodule

/* src/nbcm_div.sv */
// Restoring divider that splits a chunk number into block and page.
// Depends on nbcm_pkg; one quotient bit per cycle.
module nbcm_div
   import nbcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int STEPS = CHUNK_W;
   localparam int SC_W  = $clog2(STEPS);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SC_W-1:0]    cnt_ff, cnt_in;
   logic [CHUNK_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W:0]     trial;
   logic               fits;

   // One shift-subtract step.
   always_comb begin
      trial   = {rem_ff, quo_ff[CHUNK_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? CNT_W'(trial - {1'b0, dvs_ff}) : CNT_W'(trial);
         quo_in = {quo_ff[CHUNK_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SC_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

/* bench/tb_nand_block_chunk_manager.sv */
// Self-checking testbench for the NAND block chunk manager.
// Depends on nbcm_pkg and the nand_block_chunk_manager RTL; it predicts every
// response with its own block table model and compares each field.
module tb_nand_block_chunk_manager;
   import nbcm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] chunk_out;
      logic        chunk_used;
      logic [3:0]  blk_state;
      logic [31:0] blk_seq;
      logic [6:0]  used;
      logic [6:0]  deleted;
      logic        retire;
      logic [10:0] erased;
   } exp_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic [15:0] req_chunk = '0;
   logic [9:0]  req_block = '0;
   logic        req_use_reserve = 1'b0;
   logic        req_flash_ok = 1'b0;
   logic [3:0]  req_new_state = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_chunk_out;
   logic        rsp_chunk_used;
   logic [3:0]  rsp_block_status;
   logic [31:0] rsp_block_sequence;
   logic [6:0]  rsp_pages_used;
   logic [6:0]  rsp_pages_deleted;
   logic        rsp_retire_pending;
   logic [10:0] rsp_erased_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_data = '0;

   // Shadow copy of the block table, bitmap and allocator state.
   logic [3:0]  state_tab[1024];
   logic [31:0] seq_tab[1024];
   logic [6:0]  used_tab[1024];
   logic [6:0]  del_tab[1024];
   logic        retire_tab[1024];
   logic [63:0] bitmap_tab[1024];
   int          cur_blk = -1;
   int          cur_page = 0;
   logic [9:0]  finder = '0;
   logic [31:0] seq_next = '0;
   int          erased_blks = 0;
   int          retired_blks = 0;

   // Shadow copy of the registers.
   int sh_cpb = 64;
   int sh_first = 0;
   int sh_last = 1023;
   int sh_reserve = 2;
   int sh_no_bad = 0;

   exp_rsp_type pending_rsp[$];
   int          gap_pct = 0;
   int          last_alloc_chunk = 0;
   bit          failed = 1'b0;

   nand_block_chunk_manager DUT (.*);

   always #5 clock = ~clock;

   initial begin
      #200ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int page_size();
      if (sh_cpb == 0) return 1;
      if (sh_cpb > 64) return 64;
      return sh_cpb;
   endfunction

   function automatic void load_record(int b, inout exp_rsp_type r);
      r.blk_state = state_tab[b];
      r.blk_seq   = seq_tab[b];
      r.used      = used_tab[b];
      r.deleted   = del_tab[b];
      r.retire    = retire_tab[b];
   endfunction

   function automatic void kill_block(int b);
      state_tab[b] = BS_DEAD;
      if (sh_no_bad == 0 && retired_blks < 2047) retired_blks++;
   endfunction

   // Expected response of one command, updating the shadow state.
   function automatic exp_rsp_type predict_rsp(op_type op, logic [15:0] ch, logic [9:0] bl,
                                               logic ur, logic ok, logic [3:0] ns);
      exp_rsp_type r;
      int cpb, cb, cp, lim, from, found, reserve, b;
      bit got;
      r = '0;
      cpb = page_size();
      cb = int'(ch) / cpb;
      cp = int'(ch) % cpb;
      got = 1'b0;
      found = 0;
      case (op)
         OP_ALLOC: begin
            if (cur_blk >= 0 && state_tab[cur_blk] == BS_ALLOC && cur_page < cpb) begin
               r.chunk_out = 16'(cur_blk * cpb + cur_page);
               r.chunk_used = bitmap_tab[cur_blk][cur_page];
               load_record(cur_blk, r);
               cur_page++;
            end else begin
               cur_blk = -1;
               reserve = ur ? 0 : sh_reserve;
               lim = sh_last;
               if (erased_blks > reserve) begin
                  from = (int'(finder) < sh_first) ? sh_first : int'(finder);
                  for (b = from; b <= lim && !got; b++)
                     if (state_tab[b] == BS_EMPTY) begin
                        got = 1'b1;
                        found = b;
                     end
                  if (!got) begin
                     finder = 10'(sh_first);
                     for (b = sh_first; b <= lim && !got; b++)
                        if (state_tab[b] == BS_EMPTY) begin
                           got = 1'b1;
                           found = b;
                        end
                  end
               end
               if (got) begin
                  state_tab[found] = BS_ALLOC;
                  seq_tab[found] = seq_next;
                  seq_next++;
                  cur_blk = found;
                  cur_page = 1;
                  finder = 10'(found + 1);
                  erased_blks--;
                  r.chunk_out = 16'(found * cpb);
                  r.chunk_used = bitmap_tab[found][0];
                  load_record(found, r);
                  last_alloc_chunk = found * cpb;
               end else begin
                  r.status = STS_NO_BLOCK;
               end
            end
         end
         OP_WRITE, OP_DELETE, OP_QUERY: begin
            if (op == OP_WRITE && !ok) begin
               r.status = STS_FLASH_FAIL;
            end else if (cb < 1024) begin
               if (op == OP_WRITE) begin
                  bitmap_tab[cb][cp] = 1'b1;
                  if (used_tab[cb] < 64) used_tab[cb]++;
               end else if (op == OP_DELETE) begin
                  bitmap_tab[cb][cp] = 1'b0;
                  if (del_tab[cb] < 64) del_tab[cb]++;
               end
               r.chunk_used = bitmap_tab[cb][cp];
               load_record(cb, r);
            end
         end
         default: begin
            b = int'(bl);
            if (op == OP_ERASE && !ok) r.status = STS_FLASH_FAIL;
            case (op)
               OP_ERASE: begin
                  if (!ok) begin
                     kill_block(b);
                  end else begin
                     state_tab[b] = BS_EMPTY;
                     seq_tab[b] = '0;
                     used_tab[b] = '0;
                     del_tab[b] = '0;
                     retire_tab[b] = 1'b0;
                     bitmap_tab[b] = '0;
                     if (erased_blks < 2047) erased_blks++;
                  end
               end
               OP_MARK_BAD: kill_block(b);
               OP_RETIRE:   retire_tab[b] = 1'b1;
               default:     state_tab[b] = ns;
            endcase
            load_record(b, r);
         end
      endcase
      r.erased = 11'(erased_blks);
      return r;
   endfunction

   // Send one command beat and queue its expected response.
   task automatic send_cmd(op_type op, logic [15:0] ch, logic [9:0] bl,
                           logic ur, logic ok, logic [3:0] ns);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_chunk <= ch;
      req_block <= bl;
      req_use_reserve <= ur;
      req_flash_ok <= ok;
      req_new_state <= ns;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_rsp(op, ch, bl, ur, ok, ns));
   endtask

   // Drop start and wait until every response is back.
   task automatic drain();
      start <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   // One register write beat; the caller drops csr_valid after the last one.
   task automatic write_reg(csr_idx_type idx, int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 10'(val);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CPB:     sh_cpb = val & 8'h7F;
         CSR_FIRST:   sh_first = val;
         CSR_LAST:    sh_last = val;
         CSR_RESERVE: sh_reserve = val;
         default:     sh_no_bad = val & 1;
      endcase
   endtask

   task automatic set_regs(int cpb, int first, int last, int reserve, int no_bad);
      write_reg(CSR_CPB, cpb);
      write_reg(CSR_FIRST, first);
      write_reg(CSR_LAST, last);
      write_reg(CSR_RESERVE, reserve);
      write_reg(CSR_NO_BAD, no_bad);
      csr_valid <= 1'b0;
   endtask

   // Response checker: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      exp_rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("response beat with no command outstanding");
            failed = 1'b1;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_chunk_out !== e.chunk_out) begin
               $error("chunk_out exp %0d got %0d", e.chunk_out, rsp_chunk_out);
               failed = 1'b1;
            end
            if (rsp_chunk_used !== e.chunk_used) begin
               $error("chunk_used exp %0d got %0d", e.chunk_used, rsp_chunk_used);
               failed = 1'b1;
            end
            if (rsp_block_status !== e.blk_state) begin
               $error("block_status exp %0d got %0d", e.blk_state, rsp_block_status);
               failed = 1'b1;
            end
            if (rsp_block_sequence !== e.blk_seq) begin
               $error("block_sequence exp %0d got %0d", e.blk_seq, rsp_block_sequence);
               failed = 1'b1;
            end
            if (rsp_pages_used !== e.used) begin
               $error("pages_used exp %0d got %0d", e.used, rsp_pages_used);
               failed = 1'b1;
            end
            if (rsp_pages_deleted !== e.deleted) begin
               $error("pages_deleted exp %0d got %0d", e.deleted, rsp_pages_deleted);
               failed = 1'b1;
            end
            if (rsp_retire_pending !== e.retire) begin
               $error("retire_pending exp %0d got %0d", e.retire, rsp_retire_pending);
               failed = 1'b1;
            end
            if (rsp_erased_count !== e.erased) begin
               $error("erased_count exp %0d got %0d", e.erased, rsp_erased_count);
               failed = 1'b1;
            end
         end
      end
   end

   // Extremes, every operation and the corner cases, one command at a time.
   task automatic test_directed();
      send_cmd(OP_QUERY, 16'd0, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_ALLOC, 16'd0, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_ERASE, 16'd0, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_ERASE, 16'd0, 10'd1, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_ERASE, 16'd0, 10'd2, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_ALLOC, 16'd0, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_WRITE, 16'd0, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_WRITE, 16'd1, 10'd0, 1'b0, 1'b0, 4'd0);
      send_cmd(OP_DELETE, 16'd0, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_ALLOC, 16'd0, 10'd0, 1'b1, 1'b1, 4'd0);
      send_cmd(OP_ERASE, 16'd0, 10'd5, 1'b0, 1'b0, 4'd0);
      send_cmd(OP_MARK_BAD, 16'd0, 10'd6, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_RETIRE, 16'd0, 10'd7, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_SET_STATE, 16'd0, 10'd8, 1'b0, 1'b1, BS_EMPTY);
      send_cmd(OP_SET_STATE, 16'd0, 10'd1023, 1'b0, 1'b1, 4'd15);
      send_cmd(OP_ERASE, 16'd0, 10'd1023, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_WRITE, 16'hFFFF, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_QUERY, 16'hFFFF, 10'd0, 1'b0, 1'b1, 4'd0);
      drain();
      // One page per block: chunk numbers past the table, and a full block dropped.
      set_regs(0, 0, 1023, 0, 1);
      send_cmd(OP_QUERY, 16'hFFFF, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_DELETE, 16'd2000, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_ALLOC, 16'd0, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_ALLOC, 16'd0, 10'd0, 1'b0, 1'b1, 4'd0);
      send_cmd(OP_MARK_BAD, 16'd0, 10'd3, 1'b0, 1'b1, 4'd0);
      drain();
      // Empty window, then a reserve that refuses everything.
      set_regs(127, 5, 3, 1023, 0);
      send_cmd(OP_ALLOC, 16'd0, 10'd0, 1'b1, 1'b1, 4'd0);
      send_cmd(OP_ALLOC, 16'd0, 10'd0, 1'b0, 1'b1, 4'd0);
      drain();
   endtask

   // Random commands aimed at a block window, mostly well-formed use.
   task automatic run_random(int n, int first, int last);
      int k, sel, cpb, lo, hi;
      logic [15:0] ch;
      logic [9:0] bl;
      logic [3:0] ns;
      op_type op;
      lo = (first < last) ? first : last;
      hi = (first < last) ? last : first;
      for (k = 0; k < n; k++) begin
         cpb = page_size();
         sel = $urandom_range(99);
         if (sel < 25) op = OP_ALLOC;
         else if (sel < 50) op = OP_WRITE;
         else if (sel < 58) op = OP_DELETE;
         else if (sel < 73) op = OP_ERASE;
         else if (sel < 77) op = OP_MARK_BAD;
         else if (sel < 81) op = OP_RETIRE;
         else if (sel < 87) op = OP_SET_STATE;
         else op = OP_QUERY;
         bl = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(hi, lo));
         sel = $urandom_range(99);
         if (sel < 10) ch = 16'($urandom);
         else if (sel < 50) ch = 16'(last_alloc_chunk + $urandom_range(cpb - 1));
         else ch = 16'(int'(bl) * cpb + $urandom_range(cpb - 1));
         ns = ($urandom_range(9) < 6) ? 4'($urandom_range(3, 1)) : 4'($urandom);
         send_cmd(op, ch, bl, $urandom_range(99) < 30, $urandom_range(99) < 85, ns);
      end
      drain();
   endtask

   task automatic test_small_pages();
      gap_pct = 23;
      set_regs(8, 0, 15, 2, 0);
      run_random(550, 0, 15);
   endtask

   task automatic test_single_page();
      gap_pct = 69;
      set_regs(0, 100, 107, 0, 1);
      run_random(520, 100, 107);
   endtask

   task automatic test_oversize_pages();
      gap_pct = 0;
      set_regs(127, 1000, 1023, 5, 0);
      run_random(480, 1000, 1023);
   endtask

   task automatic test_window_extremes();
      set_regs(1, 5, 3, 0, 1);
      run_random(40, 3, 5);
      set_regs(64, 0, 1023, 1023, 0);
      run_random(40, 0, 1023);
   endtask

   initial begin
      int n;
      foreach (state_tab[i]) begin
         state_tab[i] = '0;
         seq_tab[i] = '0;
         used_tab[i] = '0;
         del_tab[i] = '0;
         retire_tab[i] = 1'b0;
         bitmap_tab[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_small_pages();
      test_single_page();
      test_oversize_pages();
      test_window_extremes();
      n = 0;
      while (pending_rsp.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (50) @(posedge clock);
      if (!failed && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
